// ----- hw/rtl/calendar_unix_time_converter_top_defines.svh -----
// Assertion macros for the calendar / Unix time converter.
// Used by the top level only; expects clk_i and rst_ni in scope for CUTC_ASSERT_IMP.
`ifndef CALENDAR_UNIX_TIME_CONVERTER_TOP_DEFINES_SVH
`define CALENDAR_UNIX_TIME_CONVERTER_TOP_DEFINES_SVH

// Generic clocked assertion, disabled while reset is active
`define CUTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication on the block clock and reset
`define CUTC_ASSERT_IMP(lbl, ante, cons, msg) \
  `CUTC_ASSERT(lbl, clk_i, rst_ni, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/cutc_pkg.sv -----
// Shared types, constants and month tables for the calendar / Unix time converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cutc_pkg;

  // Pipeline depth, output register included
  localparam int NumStages = 6;

  // Epoch register reset: Unix seconds at the start of 2001
  localparam logic [31:0] EpochReset = 32'd978307200;

  // Calendar constants
  localparam logic [7:0]  YearBias    = 8'd30;    // 2000 - 1970
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [9:0]  DaySecsHi   = 10'd675;  // 86400 >> 7
  localparam logic [6:0]  MaxYear     = 7'd99;
  localparam logic [3:0]  December    = 4'd12;
  localparam logic [3:0]  MonthsM1    = 4'd11;

  // Exact reciprocals: q = (x * M) >> S over the full input range
  localparam logic [25:0] RecipDay       = 26'd50903317; // x / 675, x < 2^25
  localparam int          RecipDayShift  = 35;
  localparam logic [16:0] RecipYear      = 17'd91930;    // x / 365, x < 2^16
  localparam int          RecipYearShift = 25;
  localparam logic [17:0] RecipMin       = 18'd139811;   // x / 60, x < 2^17
  localparam int          RecipMinShift  = 23;
  localparam logic [11:0] RecipHour      = 12'd2185;     // x / 60, x < 2^11
  localparam int          RecipHourShift = 17;

  // Request operation codes
  typedef enum logic {
    OpToUnix = 1'b0,
    OpToCal  = 1'b1
  } op_e;

  // Per-stage load enables, valid bits and operation codes
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
    logic [NumStages-1:0] op;
  } pipe_ctrl_t;

  // Decoded calendar fields, already zeroed on a range error
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       leap;
    logic       range_err;
  } cal_out_t;

  // Days before the first of month idx (0 = January)
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      default: d = leap ? 9'd366 : 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cutc_pipe_ctrl.sv -----
// Valid/ready control of the six-stage converter pipeline.
// Depends on cutc_pkg; drives load enables for all datapath stages.
`timescale 1ns / 1ps
`default_nettype none

module cutc_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 operation_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output cutc_pkg::pipe_ctrl_t ctrl_o
);
  import cutc_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] op_q, op_d;
  logic [NumStages-1:0] en;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = ~vld_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  // Valid and op advance with the data
  always_comb begin
    vld_d = vld_q;
    op_d  = op_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
      op_d[0]  = operation_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
        op_d[k]  = op_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      op_q  <= '0;
    end else begin
      vld_q <= vld_d;
      op_q  <= op_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctrl_o     = '{en: en, vld: vld_q, op: op_q};

endmodule

`default_nettype wire

// ----- hw/rtl/cutc_to_unix.sv -----
// Calendar-to-seconds datapath: day count, scale by seconds per day, add time of day.
// Depends on cutc_pkg; stage enables come from cutc_pipe_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cutc_to_unix (
  input  logic                 clk_i,
  input  cutc_pkg::pipe_ctrl_t ctrl_i,
  input  logic [6:0]           year_in_i,
  input  logic [3:0]           month_in_i,
  input  logic [4:0]           day_in_i,
  input  logic [4:0]           hours_in_i,
  input  logic [5:0]           minutes_in_i,
  input  logic [5:0]           seconds_in_i,
  output logic [31:0]          unix_o
);
  import cutc_pkg::*;

  logic [7:0]  yrs70, yrs71;
  logic [3:0]  mon_clip, midx;
  logic [15:0] days1_d, days1_q;
  logic [16:0] tod1_d, tod1_q, tod2_q;
  logic [32:0] day_secs;
  logic [31:0] prod2_q, res3_q, res4_q, res5_q;

  // Stage 1: days since 1970 and seconds of the day
  always_comb begin
    yrs70    = {1'b0, year_in_i} + YearBias;
    yrs71    = yrs70 + 8'd1;
    mon_clip = (month_in_i > December) ? December : month_in_i;
    midx     = (mon_clip == 4'd0) ? 4'd0 : mon_clip - 4'd1;
    // day zero wraps to the last day of the previous month
    days1_d  = 16'(yrs70) * 16'(DaysPerYear) + 16'(yrs71 >> 2)
             + 16'(cum_days(year_in_i[1:0] == 2'b00, midx))
             + 16'(day_in_i) - 16'd1;
    tod1_d   = 17'(hours_in_i) * 17'(SecsPerHour)
             + 17'(minutes_in_i) * 17'(SecsPerMin)
             + 17'(seconds_in_i);
  end

  // Stage 2: day count times seconds per day, modulo 2^32
  assign day_secs = 33'(days1_q) * 33'(SecsPerDay);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      days1_q <= days1_d;
      tod1_q  <= tod1_d;
    end
    if (ctrl_i.en[1]) begin
      prod2_q <= day_secs[31:0];
      tod2_q  <= tod1_q;
    end
    // Stage 3 sum, then carried to line up with the other path
    if (ctrl_i.en[2]) res3_q <= prod2_q + 32'(tod2_q);
    if (ctrl_i.en[3]) res4_q <= res3_q;
    if (ctrl_i.en[4]) res5_q <= res4_q;
  end

  assign unix_o = res5_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cutc_to_cal.sv -----
// Seconds-to-calendar datapath: epoch subtract, day/year split, month lookup.
// Depends on cutc_pkg; stage enables come from cutc_pipe_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cutc_to_cal (
  input  logic                 clk_i,
  input  cutc_pkg::pipe_ctrl_t ctrl_i,
  input  logic [31:0]          unix_seconds_i,
  input  logic [31:0]          epoch_i,
  output cutc_pkg::cal_out_t   cal_o
);
  import cutc_pkg::*;

  // Stage 1
  logic [32:0] diff;
  logic [31:0] r1_q, r2_q;
  logic        under1_q, under2_q, under3_q, under4_q, under5_q;
  // Stage 2
  logic [50:0] dprod;
  logic [15:0] days2_q, days3_q, days4_q;
  // Stage 3
  logic [24:0] rem;
  logic [32:0] yprod;
  logic [16:0] sod3_q, sod4_q;
  logic [7:0]  years3_q, years4_q;
  // Stage 4
  logic [7:0]  years_m1;
  logic [15:0] base_y, base_m, base_y4_q, base_m4_q;
  logic [34:0] mprod;
  logic [10:0] mtot4_q, mtot5_q;
  // Stage 5
  logic        gt;
  logic [7:0]  yrs_f, year5_q;
  logic [15:0] base_f;
  logic [8:0]  doy5_q;
  logic [22:0] hprod;
  logic [4:0]  hours5_q;
  logic [5:0]  sec5_q;
  // Output decode
  logic        err, leap;
  logic [3:0]  cnt;
  logic [8:0]  day_full;
  logic [5:0]  minutes;

  // Stage 1: seconds after the epoch, borrow flags underflow
  assign diff = {1'b0, unix_seconds_i} - {1'b0, epoch_i};

  // Stage 2: whole days, (r >> 7) / 675
  assign dprod = 51'(r1_q[31:7]) * 51'(RecipDay);

  // Stage 3: second of day and first year estimate
  assign rem   = r2_q[31:7] - 25'(days2_q) * 25'(DaySecsHi);
  assign yprod = 33'(days2_q) * 33'(RecipYear);

  // Stage 4: year start for the estimate and for one year less; minute of day
  always_comb begin
    years_m1 = years3_q - 8'd1;
    base_y   = 16'(years3_q) * 16'(DaysPerYear) + 16'(years3_q >> 2);
    base_m   = 16'(years_m1) * 16'(DaysPerYear) + 16'(years_m1 >> 2);
    mprod    = 35'(sod3_q) * 35'(RecipMin);
  end

  // Stage 5: correct the year when leap days push its start past the day count
  always_comb begin
    gt     = base_y4_q > days4_q;
    yrs_f  = gt ? years4_q - 8'd1 : years4_q;
    base_f = gt ? base_m4_q : base_y4_q;
    hprod  = 23'(mtot4_q) * 23'(RecipHour);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      r1_q     <= diff[31:0];
      under1_q <= diff[32];
    end
    if (ctrl_i.en[1]) begin
      days2_q  <= dprod[RecipDayShift +: 16];
      r2_q     <= r1_q;
      under2_q <= under1_q;
    end
    if (ctrl_i.en[2]) begin
      sod3_q   <= {rem[9:0], r2_q[6:0]};
      years3_q <= yprod[RecipYearShift +: 8];
      days3_q  <= days2_q;
      under3_q <= under2_q;
    end
    if (ctrl_i.en[3]) begin
      base_y4_q <= base_y;
      base_m4_q <= base_m;
      mtot4_q   <= mprod[RecipMinShift +: 11];
      years4_q  <= years3_q;
      days4_q   <= days3_q;
      sod4_q    <= sod3_q;
      under4_q  <= under3_q;
    end
    if (ctrl_i.en[4]) begin
      doy5_q   <= 9'(days4_q - base_f);
      year5_q  <= yrs_f + 8'd1;
      hours5_q <= hprod[RecipHourShift +: 5];
      sec5_q   <= 6'(sod4_q - 17'(mtot4_q) * 17'(SecsPerMin));
      mtot5_q  <= mtot4_q;
      under5_q <= under4_q;
    end
  end

  // Month lookup, day of month and final field select
  always_comb begin
    err  = under5_q | (year5_q > 8'(MaxYear));
    leap = (year5_q[1:0] == 2'b00);
    cnt  = 4'd0;
    for (int i = 1; i <= 11; i++) begin
      if (doy5_q >= cum_days(leap, 4'(i))) cnt = cnt + 4'd1;
    end
    day_full = doy5_q - cum_days(leap, (cnt > MonthsM1) ? MonthsM1 : cnt) + 9'd1;
    minutes  = 6'(mtot5_q - 11'(hours5_q) * 11'(SecsPerMin));

    cal_o = '0;
    if (err) begin
      cal_o.range_err = 1'b1;
    end else begin
      cal_o.year    = year5_q[6:0];
      cal_o.month   = cnt + 4'd1;
      cal_o.day     = day_full[4:0];
      cal_o.hours   = hours5_q;
      cal_o.minutes = minutes;
      cal_o.seconds = sec5_q;
      cal_o.leap    = leap;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/calendar_unix_time_converter_top.sv -----
// Calendar / Unix time converter, top level. Uses cutc_pkg, cutc_pipe_ctrl,
// cutc_to_unix, cutc_to_cal and the assertion macros header.
//
// Input channel (in_valid_i/in_ready_o): one request per handshake. operation_i
// low converts year/month/day/hours/minutes/seconds to Unix seconds; high splits
// unix_seconds_i, minus the epoch register, into calendar fields and leap flag.
// Output channel (out_valid_o/out_ready_i): one result per request, in order.
// Fields that do not belong to the operation read zero; range_error_o flags
// seconds before the epoch or past 2099, with all other fields zero.
// Epoch register: written through cfg_we_i/cfg_wdata_i; the user must do so only while no
// request is in flight, and the block itself does not enforce this.
// A six-stage pipeline lies between acceptance and out_valid_o (subtract, day reciprocal
// multiply, year and second-of-day split, year start, year correction, month lookup
// into the output register). Throughput is one request per cycle while the receiver
// does not stall.
// Reset empties the pipeline and loads the epoch with the start of 2001.
// When the receiver stalls, stages fill up and bubbles close; in_ready_o drops
// only once all six stages hold a request.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_unix_time_converter_top_defines.svh"

module calendar_unix_time_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Epoch register write
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] unix_seconds_i,
  input  logic [6:0]  year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hours_in_i,
  input  logic [5:0]  minutes_in_i,
  input  logic [5:0]  seconds_in_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] unix_result_o,
  output logic [6:0]  year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hours_out_o,
  output logic [5:0]  minutes_out_o,
  output logic [5:0]  seconds_out_o,
  output logic        leap_year_o,
  output logic        range_error_o
);
  import cutc_pkg::*;

  logic [31:0] epoch_q;
  pipe_ctrl_t  ctrl;
  logic [31:0] unix5;
  cal_out_t    cal5;
  logic [31:0] unix_d, unix_q;
  cal_out_t    cal_d, cal_q;

  // Epoch register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EpochReset;
    end else if (cfg_we_i) begin
      epoch_q <= cfg_wdata_i;
    end
  end

  cutc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  cutc_to_unix u_to_unix (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .year_in_i    (year_in_i),
    .month_in_i   (month_in_i),
    .day_in_i     (day_in_i),
    .hours_in_i   (hours_in_i),
    .minutes_in_i (minutes_in_i),
    .seconds_in_i (seconds_in_i),
    .unix_o       (unix5)
  );

  cutc_to_cal u_to_cal (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .unix_seconds_i (unix_seconds_i),
    .epoch_i        (epoch_q),
    .cal_o          (cal5)
  );

  // Pick the fields of the request's operation, zero the rest
  always_comb begin
    if (ctrl.op[NumStages-2] == OpToCal) begin
      unix_d = '0;
      cal_d  = cal5;
    end else begin
      unix_d = unix5;
      cal_d  = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctrl.en[NumStages-1]) begin
      unix_q <= unix_d;
      cal_q  <= cal_d;
    end
  end

  assign out_valid_o   = ctrl.vld[NumStages-1];
  assign unix_result_o = unix_q;
  assign year_out_o    = cal_q.year;
  assign month_out_o   = cal_q.month;
  assign day_out_o     = cal_q.day;
  assign hours_out_o   = cal_q.hours;
  assign minutes_out_o = cal_q.minutes;
  assign seconds_out_o = cal_q.seconds;
  assign leap_year_o   = cal_q.leap;
  assign range_error_o = cal_q.range_err;

  // Checks
  `CUTC_ASSERT_IMP(a_stall_source, !in_ready_o, out_valid_o && !out_ready_i, "input blocked without a stalled result")
  `CUTC_ASSERT_IMP(a_err_zeroes, out_valid_o && range_error_o, unix_result_o == 32'd0 && year_out_o == 7'd0 && month_out_o == 4'd0 && day_out_o == 5'd0 && !leap_year_o, "range error with nonzero fields")
  `CUTC_ASSERT_IMP(a_leap_year, out_valid_o && leap_year_o, year_out_o[1:0] == 2'b00 && month_out_o != 4'd0 && unix_result_o == 32'd0, "leap flag on a bad result")

endmodule

`default_nettype wire

// ----- bench/tb_calendar_unix_time_converter_top.sv -----
// Testbench for calendar_unix_time_converter_top: a directed table, then random requests
// under several epoch settings, checked against a local conversion model.
// Depends on cutc_pkg (op codes, pipeline depth, epoch reset value) and the top level.
`timescale 1ns / 1ps

module tb_calendar_unix_time_converter_top;
  import cutc_pkg::*;

  localparam int NumDir     = 21;
  localparam int CycleLimit = 100000;

  // One request as presented on the input channel
  typedef struct packed {
    op_e         op;
    logic [31:0] unix_seconds;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } conv_req_t;

  // One result as seen on the output channel
  typedef struct packed {
    logic [31:0] unix;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic        leap;
    logic        range_err;
  } conv_res_t;

  // Directed row: expected result typed in only where has_want is set
  typedef struct packed {
    logic      has_want;
    conv_req_t req;
    conv_res_t want;
  } dir_row_t;

  localparam conv_res_t ResNone  = '0;
  localparam conv_res_t ResRange = '{32'd0, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b1};
  // First second after the default epoch: 2001-01-01 00:00:00
  localparam conv_res_t ResEpoch = '{32'd0, 7'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0};
  // 2000-01-01 00:00:00 in Unix seconds
  localparam conv_res_t ResY2k   = '{32'd946684800, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0,
                                     1'b0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [31:0] unix_seconds_i;
  logic [6:0]  year_in_i;
  logic [3:0]  month_in_i;
  logic [4:0]  day_in_i;
  logic [4:0]  hours_in_i;
  logic [5:0]  minutes_in_i;
  logic [5:0]  seconds_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] unix_result_o;
  logic [6:0]  year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hours_out_o;
  logic [5:0]  minutes_out_o;
  logic [5:0]  seconds_out_o;
  logic        leap_year_o;
  logic        range_error_o;

  // Model state and configuration
  logic [31:0] epoch_cfg;
  logic [31:0] last_to_unix;
  int unsigned days_before_common [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                           334, 365};
  int unsigned days_before_leap   [13] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305,
                                           335, 366};

  conv_res_t   cal_exp_q [$];
  dir_row_t    dir_tab [NumDir];
  logic        stall_en;
  int          fail_cnt;
  int          res_cnt;
  int          cycle_cnt;

  calendar_unix_time_converter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .unix_seconds_i (unix_seconds_i),
    .year_in_i      (year_in_i),
    .month_in_i     (month_in_i),
    .day_in_i       (day_in_i),
    .hours_in_i     (hours_in_i),
    .minutes_in_i   (minutes_in_i),
    .seconds_in_i   (seconds_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .unix_result_o  (unix_result_o),
    .year_out_o     (year_out_o),
    .month_out_o    (month_out_o),
    .day_out_o      (day_out_o),
    .hours_out_o    (hours_out_o),
    .minutes_out_o  (minutes_out_o),
    .seconds_out_o  (seconds_out_o),
    .leap_year_o    (leap_year_o),
    .range_error_o  (range_error_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected result of one request under the current epoch
  function automatic conv_res_t conv_predict(input conv_req_t rq);
    int unsigned y70, days, r, yrs, base, yout, doy, mon, midx;
    logic        leap;
    conv_res_t   res;
    res = '0;
    if (rq.op == OpToUnix) begin
      y70  = rq.year + 32'd30;
      days = y70 * 32'd365 + ((y70 + 32'd1) >> 2);
      // month 0 counts as January, 13..15 as December
      midx = (rq.month > 4'd12) ? 32'd11 : ((rq.month == 4'd0) ? 32'd0 : rq.month - 32'd1);
      days = days + ((rq.year % 4 != 0) ? days_before_common[midx] : days_before_leap[midx]);
      days = days + rq.day - 32'd1;
      res.unix = days * 32'd86400 + rq.hours * 32'd3600 + rq.minutes * 32'd60 + rq.seconds;
      last_to_unix = res.unix;
    end else if (rq.unix_seconds < epoch_cfg) begin
      res.range_err = 1'b1;
    end else begin
      r    = rq.unix_seconds - epoch_cfg;
      days = r / 32'd86400;
      yrs  = days / 32'd365;
      base = yrs * 32'd365 + (yrs >> 2);
      if (base > days) begin
        yrs  = yrs - 32'd1;
        base = yrs * 32'd365 + (yrs >> 2);
      end
      yout = yrs + 32'd1;
      if (yout > 32'd99) begin
        res.range_err = 1'b1;
      end else begin
        doy  = days - base;
        leap = (yout % 4 == 0);
        mon  = 1;
        while (mon < 12 && doy >= (leap ? days_before_leap[mon] : days_before_common[mon]))
          mon++;
        res.year    = 7'(yout);
        res.month   = 4'(mon);
        res.day     = 5'(doy - (leap ? days_before_leap[mon-1] : days_before_common[mon-1])
                         + 32'd1);
        res.hours   = 5'((r / 32'd3600) % 32'd24);
        res.minutes = 6'((r / 32'd60) % 32'd60);
        res.seconds = 6'(r % 32'd60);
        res.leap    = leap;
      end
    end
    return res;
  endfunction

  // Print one failure line and count it
  task automatic note_fail(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      note_fail($sformatf("result %0d %s: got %0d, want %0d", res_cnt, name, got, want));
  endtask

  // Present one request, hold it until accepted, then queue its expected result
  task automatic send_req(input conv_req_t rq, input logic has_want, input conv_res_t want);
    while (stall_en && $urandom_range(99) < 16) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    operation_i    = rq.op;
    unix_seconds_i = rq.unix_seconds;
    year_in_i      = rq.year;
    month_in_i     = rq.month;
    day_in_i       = rq.day;
    hours_in_i     = rq.hours;
    minutes_in_i   = rq.minutes;
    seconds_in_i   = rq.seconds;
    do @(posedge clk_i); while (!in_ready_o);
    cal_exp_q.push_back(has_want ? want : conv_predict(rq));
    @(negedge clk_i);
  endtask

  // Drain the pipeline, then write the epoch register
  task automatic write_epoch(input logic [31:0] value);
    in_valid_i = 1'b0;
    while (cal_exp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    epoch_cfg   = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = $urandom;
  endtask

  // Random requests: mostly well-formed calendars and in-range seconds, some noise
  task automatic run_random(input int count);
    conv_req_t   rq;
    int unsigned mon_days, yr, dd;
    int          kind;
    for (int i = 0; i < count; i++) begin
      rq.unix_seconds = $urandom;
      rq.year         = 7'($urandom);
      rq.month        = 4'($urandom);
      rq.day          = 5'($urandom);
      rq.hours        = 5'($urandom);
      rq.minutes      = 6'($urandom);
      rq.seconds      = 6'($urandom);
      kind = $urandom_range(99);
      if (kind < 45) begin
        rq.op = OpToUnix;
        // below 8 keeps the full-width noise
        if (kind >= 8) begin
          rq.year  = 7'($urandom_range(99));
          rq.month = 4'($urandom_range(12, 1));
          mon_days = (rq.year % 4 == 0) ?
                     days_before_leap[rq.month] - days_before_leap[rq.month-1] :
                     days_before_common[rq.month] - days_before_common[rq.month-1];
          rq.day     = 5'($urandom_range(mon_days, 1));
          rq.hours   = 5'($urandom_range(23));
          rq.minutes = 6'($urandom_range(59));
          rq.seconds = 6'($urandom_range(59));
        end
      end else begin
        rq.op = OpToCal;
        if (kind < 52) begin
          // just below the epoch
          rq.unix_seconds = epoch_cfg - 32'd1 - ($urandom % 32'd200000);
        end else if (kind < 58) begin
          // past the end of 2099
          rq.unix_seconds = epoch_cfg + 32'd3124137600 + ($urandom % 32'd1000000000);
        end else if (kind < 64) begin
          rq.unix_seconds = $urandom;
        end else if (kind < 78) begin
          // on or one second before a year or month boundary
          yr = $urandom_range(99);
          dd = yr * 365 + (yr >> 2) + days_before_common[$urandom_range(11)];
          rq.unix_seconds = epoch_cfg + dd * 32'd86400 - $urandom_range(1);
        end else begin
          rq.unix_seconds = epoch_cfg + ($urandom % 32'd3124137600);
        end
      end
      send_req(rq, 1'b0, ResNone);
    end
  endtask

  // Receiver side: random backpressure
  always @(negedge clk_i) begin
    out_ready_i = stall_en ? ($urandom_range(99) >= 16) : 1'b1;
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    conv_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cal_exp_q.size() == 0) begin
        note_fail("result with no request pending");
      end else begin
        want = cal_exp_q.pop_front();
        cmp_field("unix_result", unix_result_o, want.unix);
        cmp_field("year_out", 32'(year_out_o), 32'(want.year));
        cmp_field("month_out", 32'(month_out_o), 32'(want.month));
        cmp_field("day_out", 32'(day_out_o), 32'(want.day));
        cmp_field("hours_out", 32'(hours_out_o), 32'(want.hours));
        cmp_field("minutes_out", 32'(minutes_out_o), 32'(want.minutes));
        cmp_field("seconds_out", 32'(seconds_out_o), 32'(want.seconds));
        cmp_field("leap_year", 32'(leap_year_o), 32'(want.leap));
        cmp_field("range_error", 32'(range_error_o), 32'(want.range_err));
        res_cnt++;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_calendar_unix_time_converter_top: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    operation_i    = OpToUnix;
    unix_seconds_i = '0;
    year_in_i      = '0;
    month_in_i     = '0;
    day_in_i       = '0;
    hours_in_i     = '0;
    minutes_in_i   = '0;
    seconds_in_i   = '0;
    epoch_cfg      = EpochReset;
    last_to_unix   = '0;
    stall_en       = 1'b1;
    fail_cnt       = 0;
    res_cnt        = 0;
    cycle_cnt      = 0;

    // fields: op, unix_seconds, year, month, day, hours, minutes, seconds
    dir_tab = '{
      // epoch itself, one second before it, zero, all ones, start of 2100
      '{1'b1, '{OpToCal, EpochReset, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResEpoch},
      '{1'b1, '{OpToCal, EpochReset - 32'd1, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResRange},
      '{1'b1, '{OpToCal, 32'd0, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResRange},
      '{1'b1, '{OpToCal, 32'hFFFF_FFFF, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F}, ResRange},
      '{1'b1, '{OpToCal, 32'd4102444800, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResRange},
      // last second of 2099
      '{1'b0, '{OpToCal, 32'd4102444799, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      '{1'b1, '{OpToUnix, 32'hFFFF_FFFF, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, ResY2k},
      '{1'b0, '{OpToUnix, 32'd0, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, ResNone},
      // month zero, months past December
      '{1'b0, '{OpToUnix, 32'd0, 7'd5, 4'd0, 5'd10, 5'd3, 6'd4, 6'd5}, ResNone},
      '{1'b0, '{OpToUnix, 32'd0, 7'd6, 4'd13, 5'd2, 5'd1, 6'd1, 6'd1}, ResNone},
      '{1'b0, '{OpToUnix, 32'd0, 7'd8, 4'd15, 5'd31, 5'd12, 6'd0, 6'd0}, ResNone},
      // day zero
      '{1'b0, '{OpToUnix, 32'd0, 7'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      '{1'b0, '{OpToUnix, 32'd0, 7'd4, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      // every field at its all-ones value, wraps past 32-bit seconds
      '{1'b0, '{OpToUnix, 32'd0, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F}, ResNone},
      // leap day, and a February 29 in a common year
      '{1'b0, '{OpToUnix, 32'd0, 7'd4, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30}, ResNone},
      '{1'b0, '{OpToUnix, 32'd0, 7'd1, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, ResNone},
      '{1'b0, '{OpToUnix, 32'hFFFF_FFFF, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      // around the 2004 leap day and year ends
      '{1'b0, '{OpToCal, 32'd1078012799, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F}, ResNone},
      '{1'b0, '{OpToCal, 32'd1078012800, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      '{1'b0, '{OpToCal, 32'd1104537599, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone},
      '{1'b0, '{OpToCal, 32'd1009843199, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, ResNone}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset epoch: directed table, then random
    for (int i = 0; i < NumDir; i++)
      send_req(dir_tab[i].req, dir_tab[i].has_want, dir_tab[i].want);
    run_random(520);

    // Epoch at zero, with no stalls on either side
    write_epoch(32'd0);
    stall_en = 1'b0;
    run_random(450);
    stall_en = 1'b1;

    // Epoch at its maximum: only the last second decodes
    write_epoch(32'hFFFF_FFFF);
    send_req('{OpToCal, 32'hFFFF_FFFF, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b1, ResEpoch);
    run_random(200);

    write_epoch($urandom);
    run_random(400);

    write_epoch(EpochReset);
    run_random(380);

    // Drain and let the pipeline settle
    in_valid_i = 1'b0;
    while (cal_exp_q.size() != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("tb_calendar_unix_time_converter_top: PASS");
    end else begin
      $display("tb_calendar_unix_time_converter_top: FAIL");
    end
    $finish;
  end

endmodule
